// File: sv/heater_zone_target_expander_core_defines.svh
// ----------------------------------------------------------------------------
// heater zone target expander - assertion macros
// shared concurrent assertion forms, clocked on the rising edge, reset low
// ----------------------------------------------------------------------------
`ifndef HEATER_ZONE_TARGET_EXPANDER_CORE_DEFINES_SVH
`define HEATER_ZONE_TARGET_EXPANDER_CORE_DEFINES_SVH

// same-cycle implication
`define HZTE_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define HZTE_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/hzte_pkg.sv
// ----------------------------------------------------------------------------
// hzte_pkg
// shared types, field widths, codes and the fixed zone map of the expander
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hzte_pkg;

    localparam int TGT_W       = 15;
    localparam int ZONE_W      = 4;
    localparam int MASK_W      = 16;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 24;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 50;
    localparam int NEAR_W      = 50;
    localparam int FAR_W       = 40;
    localparam int SIDE_N      = 4;
    localparam int SIDE_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPAND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_NEAR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_FAR  = 2'd2;

    localparam logic FUNC_SET    = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef enum logic [SIDE_W-1:0] {
        SIDE_RIGHT = 2'd0,
        SIDE_LEFT  = 2'd1,
        SIDE_UP    = 2'd2,
        SIDE_DOWN  = 2'd3
    } t_side;

    // zone index per row y, column x
    localparam logic [ZONE_W-1:0] ZONE_MAP [4][4] = '{
        '{4'd6, 4'd7, 4'd8,  4'd9},
        '{4'd5, 4'd4, 4'd11, 4'd10},
        '{4'd2, 4'd3, 4'd12, 4'd13},
        '{4'd1, 4'd0, 4'd15, 4'd14}
    };

    function automatic logic [ZONE_W-1:0] zone_at(input logic [1:0] x, input logic [1:0] y);
        return ZONE_MAP[y][x];
    endfunction

endpackage

// File: sv/heater_zone_target_expander_core.sv
// ----------------------------------------------------------------------------
// heater_zone_target_expander_core
// target table for a square heater grid with side expansion and falloff
//
// input stream: tuser selects a set transfer (write one zone target) or an
// update transfer (enable mask and target). a set transfer gives no output.
// an update runs, with expansion on, a side scan over the grid and a pick
// step, then a clearing pass over the zones, a falloff pass over every zone
// pair plus a pipe drain through the single table read port, then streams
// ZONE_COUNT results, each read and then loaded, tlast on the final one.
// the falloff pass takes one zone pair per cycle on one memory read port.
// one item at a time: input tready is low until the last result transfer.
// a stalled receiver holds the current result and the update waits for it.
// config writes are taken any cycle, meant while idle.
// reset clears the table (per-entry valid bits), the config registers, the valid flags and the state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heater_zone_target_expander_core_defines.svh"

module heater_zone_target_expander_core
    import hzte_pkg::*;
#(
    parameter int GRID_SIZE  = 4,
    parameter int ZONE_COUNT = 16,
    parameter int KEEP_BITS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // zone, target, active zones
    input  logic                  i_s_axis_tuser,  // func
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // out_zone, out_target
    output logic                  o_m_axis_tlast
);

    localparam int CW     = $clog2(GRID_SIZE);
    localparam int COST_W = $clog2(GRID_SIZE) + 1;
    localparam int ZW     = $clog2(ZONE_COUNT);
    localparam int D2_W   = $clog2(2 * (GRID_SIZE - 1) * (GRID_SIZE - 1) + 1);
    localparam int PROD_W = TGT_W + KEEP_BITS;
    localparam logic [CW-1:0]     GMAX      = CW'(GRID_SIZE - 1);
    localparam logic [COST_W-1:0] COST_EDGE = COST_W'(GRID_SIZE - 1);
    localparam logic [COST_W-1:0] COST_NONE = COST_W'(GRID_SIZE);
    localparam logic [ZW-1:0]     ZLAST     = ZW'(ZONE_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PICK,
        S_CLEAR,
        S_FALL,
        S_DRAIN,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state                r_state;
    logic                  r_expand;
    logic [NEAR_W-1:0]     r_keep_near;
    logic [FAR_W-1:0]      r_keep_far;
    logic [ZONE_COUNT-1:0] r_mask;
    logic [ZONE_COUNT-1:0] r_add;
    logic [TGT_W-1:0]      r_target;
    logic [COST_W-1:0]     r_cost [SIDE_N];
    logic [ZONE_COUNT-1:0] r_path [SIDE_N];
    logic [CW-1:0]         r_x1;
    logic [CW-1:0]         r_y1;
    logic [CW-1:0]         r_x2;
    logic [CW-1:0]         r_y2;
    logic [ZW-1:0]         r_zidx;
    logic                  r_emit_out;

    // falloff pipe
    logic                  r_p1_v;
    logic                  r_p1_ok;
    logic                  r_p1_last;
    logic                  r_p1_wr;
    logic [D2_W-1:0]       r_p1_d2;
    logic [ZW-1:0]         r_p1_z2;
    logic                  r_p2_v;
    logic                  r_p2_last;
    logic                  r_p2_wr;
    logic [TGT_W-1:0]      r_p2_val;
    logic [ZW-1:0]         r_p2_z2;
    logic [TGT_W-1:0]      r_acc;

    // result register
    logic                  r_out_valid;
    logic [ZONE_W-1:0]     r_out_zone;
    logic [TGT_W-1:0]      r_out_tgt;
    logic                  r_out_last;

    // table memory
    logic [TGT_W-1:0]      r_mem [ZONE_COUNT];
    logic [ZONE_COUNT-1:0] r_valid;
    logic [TGT_W-1:0]      r_rd_raw;
    logic                  r_rd_vld;

    logic                  in_xfer;
    logic                  out_xfer;
    logic [ZONE_W-1:0]     in_zone;
    logic [TGT_W-1:0]      in_target;
    logic [MASK_W-1:0]     in_mask;
    logic [15:0]           mask16;
    logic [ZONE_W-1:0]     z1;
    logic [ZONE_W-1:0]     z2;
    logic [CW-1:0]         adx;
    logic [CW-1:0]         ady;
    logic [D2_W-1:0]       adx_w;
    logic [D2_W-1:0]       ady_w;
    logic [D2_W-1:0]       d2;
    logic                  inner_last;
    logic [KEEP_BITS-1:0]  keep;
    logic [PROD_W-1:0]     prod;
    logic [TGT_W-1:0]      acc_next;
    logic [TGT_W-1:0]      rd_data;
    logic [ZONE_COUNT-1:0] pick_add;
    logic                  wr_en;
    logic [ZW-1:0]         wr_addr;
    logic [TGT_W-1:0]      wr_data;
    logic [ZW-1:0]         rd_addr;

    function automatic logic [ZONE_COUNT-1:0] side_path(input t_side side,
                                                        input logic [CW-1:0] x,
                                                        input logic [CW-1:0] y);
        logic [ZONE_COUNT-1:0] path;
        logic [15:0]           bit16;
        logic [CW-1:0]         ci;
        path = '0;
        for (int i = 0; i < GRID_SIZE; i++) begin
            ci    = CW'(i);
            bit16 = '0;
            case (side)
                SIDE_RIGHT: if (ci > x) bit16 = 16'(1) << zone_at(2'(ci), 2'(y));
                SIDE_LEFT:  if (ci < x) bit16 = 16'(1) << zone_at(2'(ci), 2'(y));
                SIDE_UP:    if (ci > y) bit16 = 16'(1) << zone_at(2'(x), 2'(ci));
                SIDE_DOWN:  if (ci < y) bit16 = 16'(1) << zone_at(2'(x), 2'(ci));
                default:    bit16 = '0;
            endcase
            path = path | bit16[ZONE_COUNT-1:0];
        end
        return path;
    endfunction

    function automatic logic [COST_W-1:0] side_cost(input t_side side,
                                                    input logic [CW-1:0] x,
                                                    input logic [CW-1:0] y);
        logic [COST_W-1:0] c;
        case (side)
            SIDE_RIGHT: c = COST_EDGE - COST_W'(x);
            SIDE_LEFT:  c = COST_W'(x);
            SIDE_UP:    c = COST_EDGE - COST_W'(y);
            SIDE_DOWN:  c = COST_W'(y);
            default:    c = COST_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [KEEP_BITS-1:0] keep_for(input logic [4:0] dist2,
                                                      input logic [NEAR_W-1:0] near,
                                                      input logic [FAR_W-1:0] far);
        logic [63:0]          near_ext;
        logic [63:0]          far_ext;
        logic [KEEP_BITS-1:0] k;
        near_ext = 64'(near);
        far_ext  = 64'(far);
        case (dist2)
            5'd1:    k = near_ext[0 * KEEP_BITS +: KEEP_BITS];
            5'd2:    k = near_ext[1 * KEEP_BITS +: KEEP_BITS];
            5'd4:    k = near_ext[2 * KEEP_BITS +: KEEP_BITS];
            5'd5:    k = near_ext[3 * KEEP_BITS +: KEEP_BITS];
            5'd8:    k = near_ext[4 * KEEP_BITS +: KEEP_BITS];
            5'd9:    k = far_ext[0 * KEEP_BITS +: KEEP_BITS];
            5'd10:   k = far_ext[1 * KEEP_BITS +: KEEP_BITS];
            5'd13:   k = far_ext[2 * KEEP_BITS +: KEEP_BITS];
            5'd18:   k = far_ext[3 * KEEP_BITS +: KEEP_BITS];
            default: k = '0;
        endcase
        return k;
    endfunction

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - ZONE_W - TGT_W){1'b0}}, r_out_tgt, r_out_zone};
    assign o_m_axis_tlast  = r_out_last;

    assign in_xfer   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_xfer  = r_out_valid && i_m_axis_tready;
    assign in_zone   = i_s_axis_tdata[ZONE_W-1:0];
    assign in_target = i_s_axis_tdata[ZONE_W +: TGT_W];
    assign in_mask   = i_s_axis_tdata[ZONE_W + TGT_W +: MASK_W];

    assign mask16     = 16'(r_mask);
    assign z1         = zone_at(2'(r_x1), 2'(r_y1));
    assign z2         = zone_at(2'(r_x2), 2'(r_y2));
    assign adx        = (r_x2 > r_x1) ? r_x2 - r_x1 : r_x1 - r_x2;
    assign ady        = (r_y2 > r_y1) ? r_y2 - r_y1 : r_y1 - r_y2;
    assign adx_w      = D2_W'(adx);
    assign ady_w      = D2_W'(ady);
    assign d2         = adx_w * adx_w + ady_w * ady_w;
    assign inner_last = (r_x1 == GMAX) && (r_y1 == GMAX);
    assign rd_data    = r_rd_vld ? r_rd_raw : '0;
    assign keep       = keep_for(5'(r_p1_d2), r_keep_near, r_keep_far);
    assign prod       = PROD_W'(rd_data) * PROD_W'(keep);
    assign acc_next   = (r_p2_val > r_acc) ? r_p2_val : r_acc;

    hzte_side_pick #(
        .COST_W     (COST_W),
        .ZONE_COUNT (ZONE_COUNT)
    ) u_pick (
        .i_cost (r_cost),
        .i_path (r_path),
        .o_add  (pick_add)
    );

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_zidx;
        wr_data = '0;
        rd_addr = r_zidx;
        case (r_state)
            S_IDLE: begin
                wr_en   = in_xfer && (i_s_axis_tuser == FUNC_SET)
                          && ({1'b0, in_zone} < 5'(ZONE_COUNT));
                wr_addr = in_zone[ZW-1:0];
                wr_data = in_target;
            end
            S_CLEAR: begin
                wr_en   = r_add[r_zidx] || !r_mask[r_zidx];
                wr_data = r_add[r_zidx] ? r_target : '0;
            end
            S_FALL, S_DRAIN: begin
                wr_en   = r_p2_v && r_p2_last && r_p2_wr;
                wr_addr = r_p2_z2;
                wr_data = acc_next;
                rd_addr = z1[ZW-1:0];
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_raw <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_valid[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_expand    <= 1'b0;
            r_keep_near <= '0;
            r_keep_far  <= '0;
            r_p1_v      <= 1'b0;
            r_p2_v      <= 1'b0;
            r_out_valid <= 1'b0;
            r_emit_out  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EXPAND:    r_expand    <= i_cfg_data[0];
                    CFG_KEEP_NEAR: r_keep_near <= i_cfg_data[NEAR_W-1:0];
                    CFG_KEEP_FAR:  r_keep_far  <= i_cfg_data[FAR_W-1:0];
                    default:       r_expand    <= r_expand;
                endcase
            end

            // falloff pipe, stage one: table read returns, stage two: scaled value
            r_p1_v    <= (r_state == S_FALL);
            r_p1_ok   <= mask16[z1] && !mask16[z2];
            r_p1_d2   <= d2;
            r_p1_last <= inner_last;
            r_p1_wr   <= !mask16[z2] && ({1'b0, z2} < 5'(ZONE_COUNT));
            r_p1_z2   <= z2[ZW-1:0];
            r_p2_v    <= r_p1_v;
            r_p2_val  <= r_p1_ok ? prod[PROD_W-1:KEEP_BITS] : '0;
            r_p2_last <= r_p1_last;
            r_p2_wr   <= r_p1_wr;
            r_p2_z2   <= r_p1_z2;
            if (r_p2_v) begin
                r_acc <= r_p2_last ? '0 : acc_next;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_s_axis_tuser == FUNC_UPDATE)) begin
                        r_mask   <= in_mask[ZONE_COUNT-1:0];
                        r_target <= in_target;
                        r_add    <= '0;
                        r_x1     <= '0;
                        r_y1     <= '0;
                        r_zidx   <= '0;
                        for (int s = 0; s < SIDE_N; s++) begin
                            r_cost[s] <= COST_NONE;
                            r_path[s] <= '0;
                        end
                        r_state <= r_expand ? S_SCAN : S_CLEAR;
                    end
                end
                S_SCAN: begin
                    for (int s = 0; s < SIDE_N; s++) begin
                        if (mask16[z1]
                            && side_cost(t_side'(s), r_x1, r_y1) < r_cost[s]) begin
                            r_cost[s] <= side_cost(t_side'(s), r_x1, r_y1);
                            r_path[s] <= side_path(t_side'(s), r_x1, r_y1);
                        end
                    end
                    if (r_y1 == GMAX) begin
                        r_y1 <= '0;
                        r_x1 <= r_x1 + 1'b1;
                        if (r_x1 == GMAX) begin
                            r_x1    <= '0;
                            r_state <= S_PICK;
                        end
                    end else begin
                        r_y1 <= r_y1 + 1'b1;
                    end
                end
                S_PICK: begin
                    r_add   <= pick_add;
                    r_mask  <= r_mask | pick_add;
                    r_state <= S_CLEAR;
                end
                S_CLEAR: begin
                    r_acc <= '0;
                    r_x1  <= '0;
                    r_y1  <= '0;
                    r_x2  <= '0;
                    r_y2  <= '0;
                    if (r_zidx == ZLAST) begin
                        r_zidx  <= '0;
                        r_state <= S_FALL;
                    end else begin
                        r_zidx <= r_zidx + 1'b1;
                    end
                end
                S_FALL: begin
                    if (r_y1 != GMAX) begin
                        r_y1 <= r_y1 + 1'b1;
                    end else begin
                        r_y1 <= '0;
                        if (r_x1 != GMAX) begin
                            r_x1 <= r_x1 + 1'b1;
                        end else begin
                            r_x1 <= '0;
                            if (r_y2 != GMAX) begin
                                r_y2 <= r_y2 + 1'b1;
                            end else begin
                                r_y2 <= '0;
                                if (r_x2 != GMAX) begin
                                    r_x2 <= r_x2 + 1'b1;
                                end else begin
                                    r_state <= S_DRAIN;
                                end
                            end
                        end
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_v && !r_p2_v) begin
                        r_zidx  <= '0;
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_emit_out <= 1'b0;
                    r_state    <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    if (!r_emit_out) begin
                        r_out_valid <= 1'b1;
                        r_out_zone  <= ZONE_W'(r_zidx);
                        r_out_tgt   <= rd_data;
                        r_out_last  <= (r_zidx == ZLAST);
                        r_emit_out  <= 1'b1;
                    end else if (out_xfer) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_zidx  <= r_zidx + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `HZTE_ASSERT_IMPL(a_busy_while_result, i_clk, i_rst_n, o_m_axis_tvalid, !o_s_axis_tready, "input ready while a result is pending")
    `HZTE_ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, out_xfer && o_m_axis_tlast, o_s_axis_tready, "not idle after the last result transfer")
    `HZTE_ASSERT_IMPL(a_add_in_mask, i_clk, i_rst_n, r_state == S_CLEAR, (r_add & ~r_mask) == '0, "expanded zone missing from the enabled set")
    `HZTE_ASSERT_IMPL(a_falloff_disabled, i_clk, i_rst_n, wr_en && (r_state == S_FALL || r_state == S_DRAIN), !r_mask[wr_addr], "falloff write to an enabled zone")

endmodule

// File: sv/hzte_side_pick.sv
// ----------------------------------------------------------------------------
// hzte_side_pick
// picks the two cheapest grid sides, ties in side order, and merges their paths
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hzte_side_pick
    import hzte_pkg::*;
#(
    parameter int COST_W     = 3,
    parameter int ZONE_COUNT = 16
) (
    input  logic [COST_W-1:0]     i_cost [SIDE_N],
    input  logic [ZONE_COUNT-1:0] i_path [SIDE_N],
    output logic [ZONE_COUNT-1:0] o_add
);

    logic [SIDE_W-1:0] first;
    logic [SIDE_W-1:0] second;
    logic              have_second;

    always_comb begin
        first = '0;
        for (int s = 1; s < SIDE_N; s++) begin
            if (i_cost[s] < i_cost[first]) begin
                first = SIDE_W'(s);
            end
        end
        second      = '0;
        have_second = 1'b0;
        for (int s = 0; s < SIDE_N; s++) begin
            if (SIDE_W'(s) != first) begin
                if (!have_second || i_cost[s] < i_cost[second]) begin
                    second      = SIDE_W'(s);
                    have_second = 1'b1;
                end
            end
        end
        o_add = i_path[first] | i_path[second];
    end

endmodule
